[hw/rtl/ffa_pkg.sv]
// Shared constants, request kinds and the command/status bundles of the
// first-fit chunk allocator. No dependencies; used by every RTL file.
package ffa_pkg;

  localparam int POOL_CHUNKS      = 1024;
  localparam int REGIONS          = 16;
  localparam int WORDS_PER_REGION = (POOL_CHUNKS + 31) / 32;
  localparam int WORD_W           = (WORDS_PER_REGION > 1) ? $clog2(WORDS_PER_REGION) : 1;
  localparam int REGION_W         = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int IDX_W            = WORD_W + 5;
  localparam int MEM_AW           = REGION_W + WORD_W;
  localparam int MEM_DEPTH        = 1 << MEM_AW;

  localparam int KIND_W   = 2;
  localparam int REGION_FW = 4;
  localparam int COUNT_W  = 8;
  localparam int OFFSET_W = 14;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef struct packed {
    logic sweep;       // zero the memory word at the sweep pointer, advance
    logic req_load;    // capture the incoming request
    logic word_clr;    // word pointer to zero
    logic scan_start;  // clear run length and lane
    logic scan_step;   // evaluate one word or byte lane of the scan
    logic word_inc;    // advance word pointer
    logic free_load;   // load run bounds of a free request
    logic mem_rd;      // registered read at the current word
    logic wr_zero;     // write zero at the current word
    logic wr_mark;     // write back the read word with the run set or cleared
    logic out_load;    // load the result register
    logic out_grant;   // granted value for the result
  } ffa_cmd_t;

  typedef struct packed {
    logic  sweep_last;
    logic  region_ok;
    kind_t kind;
    logic  count_nz;
    logic  free_ok;
    logic  found;
    logic  word_done;
    logic  last_word;
    logic  mark_last;
    logic  out_free;
  } ffa_status_t;

endpackage

[hw/rtl/ffa_ctrl.sv]
// Request sequencer of the first-fit chunk allocator: one-hot state machine
// that drives the datapath through ffa_pkg command and status bundles.
module ffa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  ffa_pkg::ffa_status_t st,
  output ffa_pkg::ffa_cmd_t    cmd
);
  import ffa_pkg::*;

  typedef enum logic [8:0] {
    S_INIT    = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_DECODE  = 9'b000000100,
    S_SCAN_RD = 9'b000001000,
    S_SCAN_EV = 9'b000010000,
    S_MARK_RD = 9'b000100000,
    S_MARK_WR = 9'b001000000,
    S_CLEAR   = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   grant_r, grant_nxt;

  always_comb begin
    state_nxt = state_r;
    grant_nxt = grant_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd.sweep = 1'b1;
        if (st.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.req_load = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        grant_nxt = 1'b0;
        state_nxt = S_DONE;
        if (st.region_ok) begin
          unique case (st.kind)
            KIND_ALLOC: begin
              if (st.count_nz) begin
                cmd.scan_start = 1'b1;
                cmd.word_clr   = 1'b1;
                state_nxt      = S_SCAN_RD;
              end
            end
            KIND_FREE: begin
              if (st.free_ok) begin
                cmd.free_load = 1'b1;
                state_nxt     = S_MARK_RD;
              end
            end
            KIND_CLEAR: begin
              cmd.word_clr = 1'b1;
              state_nxt    = S_CLEAR;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        cmd.scan_step = 1'b1;
        if (st.found) begin
          state_nxt = S_MARK_RD;
        end else if (st.word_done) begin
          if (st.last_word) begin
            grant_nxt = 1'b0;
            state_nxt = S_DONE;
          end else begin
            cmd.word_inc = 1'b1;
            state_nxt    = S_SCAN_RD;
          end
        end
      end
      S_MARK_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_MARK_WR;
      end
      S_MARK_WR: begin
        cmd.wr_mark = 1'b1;
        if (st.mark_last) begin
          grant_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.word_inc = 1'b1;
          state_nxt    = S_MARK_RD;
        end
      end
      S_CLEAR: begin
        cmd.wr_zero = 1'b1;
        if (st.last_word) begin
          grant_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.word_inc = 1'b1;
        end
      end
      S_DONE: begin
        cmd.out_grant = grant_r;
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      grant_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      grant_r <= grant_nxt;
    end
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DECODE))
    else $error("accepted request not decoded next cycle");

  a_result_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> st.out_free)
    else $error("result loaded over an untaken result");

  a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_mark |-> $past(cmd.mem_rd))
    else $error("mark write without preceding read");

endmodule

[hw/rtl/ffa_dp.sv]
// Datapath of the first-fit chunk allocator: occupancy memory, request and
// scan registers, run masks and result register. Uses ffa_pkg.
module ffa_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [31:0]          in_tdata,
  input  logic [1:0]           in_tuser,
  output logic [15:0]          out_tdata,
  output logic                 out_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  ffa_pkg::ffa_cmd_t    cmd,
  output ffa_pkg::ffa_status_t st
);
  import ffa_pkg::*;

  logic [31:0] mem [MEM_DEPTH];

  kind_t                kind_r;
  logic [REGION_FW-1:0] region_r;
  logic [COUNT_W-1:0]   count_r;
  logic [OFFSET_W-1:0]  offset_r;
  logic [MEM_AW-1:0]    sweep_r;
  logic [WORD_W-1:0]    word_r;
  logic [1:0]           lane_r;
  logic [COUNT_W-1:0]   run_r, run_nxt;
  logic [IDX_W-1:0]     start_r, end_r, end_nxt, alloc_start;
  logic [31:0]          rdata_r;
  logic                 out_valid_r, grant_out_r;
  logic [OFFSET_W-1:0]  run_offset_r;

  logic [MEM_AW-1:0]    mem_addr;
  logic [31:0]          beyond, eff, mark_mask, wdata;
  logic                 mem_we, all_taken, all_free;
  logic [7:0]           lane_bits;
  logic [8:0]           lane_run, run_sum;
  logic                 lane_hit, found, word_done;
  logic [2:0]           lane_pos;
  logic [11:0]          base;
  logic [IDX_W-1:0]     free_start, free_end;
  logic [4:0]           lo, hi;

  assign mem_addr = cmd.sweep ? sweep_r : {region_r[REGION_W-1:0], word_r};

  // chunks past the pool end read as taken
  always_comb begin
    for (int j = 0; j < 32; j++) begin
      beyond[j] = {1'b0, word_r, 5'(j)} >= (IDX_W + 1)'(POOL_CHUNKS);
    end
  end

  assign eff       = rdata_r | beyond;
  assign all_taken = &eff;
  assign all_free  = ~|eff;
  assign lane_bits = eff[{lane_r, 3'b000} +: 8];
  assign run_sum   = {1'b0, run_r} + 9'd32;

  always_comb begin
    lane_run = {1'b0, run_r};
    lane_hit = 1'b0;
    lane_pos = 3'd0;
    for (int j = 0; j < 8; j++) begin
      if (lane_bits[j]) begin
        lane_run = 9'd0;
      end else begin
        lane_run = lane_run + 9'd1;
        if (!lane_hit && lane_run == {1'b0, count_r}) begin
          lane_hit = 1'b1;
          lane_pos = 3'(j);
        end
      end
    end
  end

  always_comb begin
    found     = 1'b0;
    word_done = 1'b0;
    run_nxt   = run_r;
    end_nxt   = {word_r, lane_r, lane_pos};
    if (lane_r == 2'd0 && all_taken) begin
      run_nxt   = '0;
      word_done = 1'b1;
    end else if (lane_r == 2'd0 && all_free) begin
      if (run_sum >= {1'b0, count_r}) begin
        found   = 1'b1;
        end_nxt = {word_r, 5'(count_r - run_r - 8'd1)};
      end else begin
        run_nxt   = run_sum[7:0];
        word_done = 1'b1;
      end
    end else if (lane_hit) begin
      found = 1'b1;
    end else begin
      run_nxt   = lane_run[7:0];
      word_done = (lane_r == 2'd3);
    end
  end

  assign alloc_start = IDX_W'(16'(end_nxt) + 16'd1 - 16'(count_r));

  assign base       = offset_r[13:2];
  assign free_start = IDX_W'(base);
  assign free_end   = IDX_W'(13'(base) + 13'(count_r) - 13'd1);

  assign lo        = (word_r == start_r[IDX_W-1:5]) ? start_r[4:0] : 5'd0;
  assign hi        = (word_r == end_r[IDX_W-1:5]) ? end_r[4:0] : 5'd31;
  assign mark_mask = ({32{1'b1}} << lo) & ({32{1'b1}} >> (5'd31 - hi));

  assign mem_we = cmd.sweep | cmd.wr_zero | cmd.wr_mark;
  assign wdata  = !cmd.wr_mark ? 32'd0 :
                  (kind_r == KIND_ALLOC) ? (rdata_r | mark_mask) : (rdata_r & ~mark_mask);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= wdata;
    if (cmd.mem_rd) rdata_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      kind_r   <= kind_t'(in_tuser);
      region_r <= in_tdata[3:0];
      count_r  <= in_tdata[11:4];
      offset_r <= in_tdata[25:12];
    end
    if (cmd.word_clr) begin
      word_r <= '0;
    end else if (cmd.word_inc) begin
      word_r <= word_r + 1'b1;
    end else if (cmd.free_load) begin
      word_r <= free_start[IDX_W-1:5];
    end else if (cmd.scan_step && found) begin
      word_r <= alloc_start[IDX_W-1:5];
    end
    if (cmd.scan_start) begin
      lane_r <= 2'd0;
      run_r  <= '0;
    end else if (cmd.scan_step) begin
      lane_r <= (found || word_done) ? 2'd0 : lane_r + 2'd1;
      run_r  <= run_nxt;
    end
    if (cmd.free_load) begin
      start_r <= free_start;
      end_r   <= free_end;
    end else if (cmd.scan_step && found) begin
      start_r <= alloc_start;
      end_r   <= end_nxt;
    end
    if (cmd.out_load) begin
      grant_out_r  <= cmd.out_grant;
      run_offset_r <= (cmd.out_grant && kind_r == KIND_ALLOC) ?
                      OFFSET_W'({start_r, 2'b00}) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.sweep) sweep_r <= sweep_r + 1'b1;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    st.sweep_last = (sweep_r == MEM_AW'(MEM_DEPTH - 1));
    st.region_ok  = {1'b0, region_r} < 5'(REGIONS);
    st.kind       = kind_r;
    st.count_nz   = (count_r != '0);
    st.free_ok    = (count_r != '0) && (offset_r[1:0] == 2'b00) &&
                    ({1'b0, offset_r} < 15'(POOL_CHUNKS * 4)) &&
                    ((13'(base) + 13'(count_r)) <= 13'(POOL_CHUNKS));
    st.found      = found;
    st.word_done  = word_done;
    st.last_word  = (word_r == WORD_W'(WORDS_PER_REGION - 1));
    st.mark_last  = (word_r == end_r[IDX_W-1:5]);
    st.out_free   = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = grant_out_r;
  assign out_tdata  = {2'b00, run_offset_r};

  a_run_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_step && !found) |=> (run_r < count_r))
    else $error("free run reached request length without a hit");

  a_mark_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_mark |-> (word_r >= start_r[IDX_W-1:5] && word_r <= end_r[IDX_W-1:5]))
    else $error("mark write outside the run's words");

  a_run_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_step && found) |=> (start_r <= end_r))
    else $error("allocated run starts after it ends");

endmodule

[hw/rtl/first_fit_bitmap_chunk_allocator.sv]
// First-fit bitmap allocator of four-byte chunks, one occupancy bitmap per
// region held in a 32-bit-wide memory (ffa_pkg::MEM_DEPTH words, 512 here).
// After reset a clearing pass writes every memory word once, one per cycle,
// with in_tready low. Requests are then served one at a time: allocate
// reads the region's words from chunk zero, evaluates a word that is wholly
// free or wholly taken as a whole and a mixed word one byte lane per cycle,
// then does a read-modify-write on each word of the found run; free does a
// read-modify-write on each word of the run, clear writes zero to each word
// of the region; each request is decoded first and ends in the result
// register. The occupancy memory is single-port.
// The result register lets a new request be taken while a result waits.
// Depends on ffa_pkg, ffa_ctrl and ffa_dp.
module first_fit_bitmap_chunk_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // region[3:0], chunk_count[11:4], req_offset[25:12], zeros
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // run_offset[13:0], zeros
  output logic        out_tuser   // granted
);
  import ffa_pkg::*;

  ffa_cmd_t    cmd;
  ffa_status_t st;

  ffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  ffa_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .st         (st)
  );

endmodule
